// ===== rtl/core/trme_pkg.sv =====
// ----------------------------------------------------------------------------
// trme_pkg
// Shared widths, register indexes, reset values and result codes for the
// token rate mantissa/exponent encoder.
// ----------------------------------------------------------------------------
package trme_pkg;

    localparam int MANTISSA_BITS_DEF = 12;
    localparam int CREDITS_LOG2_DEF  = 4;

    localparam int RATE_W        = 40;
    localparam int CLK_MHZ_W     = 10;
    localparam int PRESCALER_W   = 5;
    localparam int HZ_PER_MHZ_W  = 20;
    localparam int HZ_W          = 30;   // 1023 MHz fits below 2^30
    localparam int EXP_W         = 6;
    localparam int START_W       = 7;    // start exponent spans 0..64
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 10;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_REJECT = 2'd1;
    localparam t_status ST_RANGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLK_MHZ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER = 2'd1;

    localparam logic [CLK_MHZ_W-1:0]    CLK_MHZ_RST   = 10'd600;
    localparam logic [PRESCALER_W-1:0]  PRESCALER_RST = 5'd0;
    localparam logic [HZ_PER_MHZ_W-1:0] HZ_PER_MHZ    = 20'd1000000;

    // Start exponent of an empty tick clock, and the largest usable one
    localparam logic [START_W-1:0] START_EMPTY = 7'd64;
    localparam logic [START_W-1:0] START_LAST  = 7'd63;

    typedef struct packed {
        logic done;
        logic range_err;
    } t_div_stat;

endpackage

// ===== rtl/core/trme_in_if.sv =====
// ----------------------------------------------------------------------------
// trme_in_if
// Input channel: one rate request per transfer.
// ----------------------------------------------------------------------------
interface trme_in_if;
    import trme_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate_bytes;
    logic              clamp;

    modport source (output valid, rate_bytes, clamp, input ready);
    modport sink   (input valid, rate_bytes, clamp, output ready);

endinterface

// ===== rtl/core/trme_out_if.sv =====
// ----------------------------------------------------------------------------
// trme_out_if
// Result channel: mantissa, exponent and status per transfer.
// ----------------------------------------------------------------------------
interface trme_out_if #(
    parameter int MANT_W = trme_pkg::MANTISSA_BITS_DEF
);
    import trme_pkg::*;

    logic              valid;
    logic              ready;
    logic [MANT_W-1:0] mantissa;
    logic [EXP_W-1:0]  exponent;
    t_status           status;

    modport source (output valid, mantissa, exponent, status, input ready);
    modport sink   (input valid, mantissa, exponent, status, output ready);

endinterface

// ===== rtl/core/trme_derive.sv =====
// ----------------------------------------------------------------------------
// trme_derive
// Holds the clock configuration and derives tick rate, maximum rate and
// start exponent after reset and after every register write.
// ----------------------------------------------------------------------------
module trme_derive #(
    parameter int MANTISSA_BITS         = trme_pkg::MANTISSA_BITS_DEF,
    parameter int CREDITS_PER_BYTE_LOG2 = trme_pkg::CREDITS_LOG2_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_we,
    input  logic [trme_pkg::CFG_IDX_W-1:0]                 i_cfg_idx,
    input  logic [trme_pkg::CFG_DATA_W-1:0]                i_cfg_data,
    output logic [trme_pkg::HZ_W-1:0]                      o_hz,
    output logic [trme_pkg::HZ_W+MANTISSA_BITS-CREDITS_PER_BYTE_LOG2-1:0] o_peak_rate,
    output logic [trme_pkg::START_W-1:0]                   o_start_exp,
    output logic                                           o_busy
);
    import trme_pkg::*;

    localparam int SCAN_W = HZ_W + MANTISSA_BITS;
    localparam int MAXR_W = SCAN_W - CREDITS_PER_BYTE_LOG2;

    localparam logic [2:0] D_IDLE  = 3'd0;
    localparam logic [2:0] D_MUL   = 3'd1;
    localparam logic [2:0] D_SHIFT = 3'd2;
    localparam logic [2:0] D_MAX   = 3'd3;
    localparam logic [2:0] D_SCAN  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [CLK_MHZ_W-1:0]   r_clk_mhz;
    logic [PRESCALER_W-1:0] r_presc;
    logic [HZ_W-1:0]        r_prod;
    logic [HZ_W-1:0]        r_hz;
    logic [MAXR_W-1:0]      r_max;
    logic [SCAN_W-1:0]      r_scan;
    logic [START_W-1:0]     r_start;

    logic                   cfg_hit;
    logic [HZ_W-1:0]        prod;
    logic [SCAN_W-1:0]      full;
    logic [SCAN_W-1:0]      maxv;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_CLK_MHZ || i_cfg_idx == CFG_PRESCALER);
    assign prod    = HZ_W'(r_clk_mhz) * HZ_W'(HZ_PER_MHZ);
    // hz * (2^M - 1) as shift and subtract
    assign full    = (SCAN_W'(r_hz) << MANTISSA_BITS) - SCAN_W'(r_hz);
    assign maxv    = full >> CREDITS_PER_BYTE_LOG2;

    always_comb begin
        n_state = r_state;
        if (cfg_hit) begin
            n_state = D_MUL;
        end else begin
            unique case (r_state)
                D_IDLE:  n_state = D_IDLE;
                D_MUL:   n_state = D_SHIFT;
                D_SHIFT: n_state = D_MAX;
                D_MAX:   n_state = D_SCAN;
                D_SCAN: begin
                    if (r_scan == '0) begin
                        n_state = D_IDLE;
                    end
                end
                default: n_state = D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= D_MUL;
            r_clk_mhz <= CLK_MHZ_RST;
            r_presc   <= PRESCALER_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == CFG_CLK_MHZ) begin
                r_clk_mhz <= i_cfg_data[CLK_MHZ_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_PRESCALER) begin
                r_presc <= i_cfg_data[PRESCALER_W-1:0];
            end
        end
    end

    // Leading-one search: one bit per cycle, count the start exponent down
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_MUL:   r_prod <= prod;
            D_SHIFT: r_hz   <= r_prod >> r_presc;
            D_MAX: begin
                r_max   <= maxv[MAXR_W-1:0];
                r_scan  <= maxv << CREDITS_PER_BYTE_LOG2;
                r_start <= START_EMPTY;
            end
            D_SCAN: begin
                if (r_scan != '0) begin
                    r_scan  <= r_scan >> 1;
                    r_start <= r_start - START_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_hz        = r_hz;
    assign o_peak_rate = r_max;
    assign o_start_exp = r_start;
    assign o_busy      = (r_state != D_IDLE);

endmodule

// ===== rtl/core/trme_div.sv =====
// ----------------------------------------------------------------------------
// trme_div
// Bit-serial restoring divider that stops once the mantissa window is full or
// the dividend runs out; the bit position where it stops gives the exponent.
// ----------------------------------------------------------------------------
module trme_div #(
    parameter int MANTISSA_BITS         = trme_pkg::MANTISSA_BITS_DEF,
    parameter int CREDITS_PER_BYTE_LOG2 = trme_pkg::CREDITS_LOG2_DEF,
    parameter int RATE_SEL_W            = trme_pkg::RATE_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [RATE_SEL_W-1:0]            i_rate,
    input  logic [trme_pkg::HZ_W-1:0]        i_hz,
    input  logic [trme_pkg::START_W-1:0]     i_start_exp,
    output trme_pkg::t_div_stat              o_stat,
    output logic [MANTISSA_BITS-1:0]         o_mant,
    output logic [trme_pkg::EXP_W-1:0]       o_exp
);
    import trme_pkg::*;

    // Highest dividend bit position fed in, plus one
    localparam int POS_W = $clog2(64 + CREDITS_PER_BYTE_LOG2 + RATE_SEL_W);
    localparam int CNT_W = $clog2(MANTISSA_BITS + 1);

    logic                     r_busy;
    logic                     r_done;
    logic                     r_range;
    logic [RATE_SEL_W-1:0]    r_rate;
    logic [HZ_W-1:0]          r_rem;
    logic [POS_W-1:0]         r_pos;
    logic [MANTISSA_BITS-1:0] r_q;
    logic [CNT_W-1:0]         r_cnt;
    logic [EXP_W-1:0]         r_exp;

    logic [HZ_W:0]            trial;
    logic [HZ_W:0]            diff;
    logic                     ge;
    logic [HZ_W-1:0]          n_rem;
    logic [MANTISSA_BITS-1:0] n_q;
    logic                     counting;
    logic [CNT_W-1:0]         n_cnt;
    logic                     stop;
    logic [POS_W-1:0]         start_pos;
    logic [POS_W-1:0]         exp_diff;

    assign trial     = {r_rem, r_rate[RATE_SEL_W-1]};
    assign diff      = trial - {1'b0, i_hz};
    assign ge        = (trial >= {1'b0, i_hz});
    assign n_rem     = ge ? diff[HZ_W-1:0] : trial[HZ_W-1:0];
    assign n_q       = {r_q[MANTISSA_BITS-2:0], ge};
    // Count quotient bits from the leading one on
    assign counting  = (r_cnt != '0) || ge;
    assign n_cnt     = counting ? r_cnt + CNT_W'(1) : r_cnt;
    assign stop      = (n_cnt == CNT_W'(MANTISSA_BITS)) || (r_pos == '0);
    assign start_pos = POS_W'(i_start_exp);
    assign exp_diff  = start_pos - r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && stop) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rate <= i_rate;
            r_rem  <= '0;
            r_pos  <= start_pos + POS_W'(CREDITS_PER_BYTE_LOG2 + RATE_SEL_W - 1);
            r_q    <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rate <= r_rate << 1;
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_cnt  <= n_cnt;
            r_pos  <= r_pos - POS_W'(1);
            if (stop) begin
                r_range <= (r_pos > start_pos);
                r_exp   <= exp_diff[EXP_W-1:0];
            end
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.range_err = r_range;
    assign o_mant           = r_q;
    assign o_exp            = r_exp;

endmodule

// ===== rtl/core/token_rate_mantissa_exponent_encoder_top.sv =====
// ----------------------------------------------------------------------------
// token_rate_mantissa_exponent_encoder_top
// Byte rate to token bucket mantissa/exponent encoder.
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance a check state compares the
// rate against the maximum; a rejected rate or an empty tick clock finishes there.
// Otherwise the bit-serial divider runs one quotient bit per cycle from dividend
// bit start_exponent + CREDITS_PER_BYTE_LOG2 + RW - 1 (39 by default) downward
// and stops as soon as MANTISSA_BITS bits from the leading one on are in, or
// the last dividend bit is in. The divider result passes through the done state
// and is then handed to the output register, where it sits. After reset and
// after each write of clk_mhz or prescaler the tick rate, maximum rate and start
// exponent are re-derived with a one-bit-per-cycle leading-one search; input
// ready stays low during that time.
// ----------------------------------------------------------------------------
module token_rate_mantissa_exponent_encoder_top #(
    parameter int MANTISSA_BITS         = trme_pkg::MANTISSA_BITS_DEF,
    parameter int CREDITS_PER_BYTE_LOG2 = trme_pkg::CREDITS_LOG2_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [trme_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trme_pkg::CFG_DATA_W-1:0] i_cfg_data,
    trme_in_if.sink                         i_in,
    trme_out_if.source                      o_out
);
    import trme_pkg::*;

    localparam int MAXR_W = HZ_W + MANTISSA_BITS - CREDITS_PER_BYTE_LOG2;
    localparam int RW     = (MAXR_W > RATE_W) ? MAXR_W : RATE_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [RATE_W-1:0]        r_rate;
    logic                     r_clamp;
    logic [MANTISSA_BITS-1:0] r_res_mant, n_res_mant;
    logic [EXP_W-1:0]         r_res_exp, n_res_exp;
    t_status                  r_res_status, n_res_status;
    logic                     r_out_valid;
    logic [MANTISSA_BITS-1:0] r_out_mant;
    logic [EXP_W-1:0]         r_out_exp;
    t_status                  r_out_status;

    logic [HZ_W-1:0]          hz;
    logic [MAXR_W-1:0]        peak_rate;
    logic [START_W-1:0]       start_exp;
    logic                     derive_busy;

    logic                     div_start;
    t_div_stat                div_stat;
    logic [MANTISSA_BITS-1:0] div_mant;
    logic [EXP_W-1:0]         div_exp;

    logic                     in_xfer;
    logic                     out_free;
    logic [RW-1:0]            rate_ext;
    logic [RW-1:0]            max_ext;
    logic                     over;
    logic [RW-1:0]            rate_sel;
    logic                     no_clock;

    trme_derive #(
        .MANTISSA_BITS         (MANTISSA_BITS),
        .CREDITS_PER_BYTE_LOG2 (CREDITS_PER_BYTE_LOG2)
    ) u_derive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_hz        (hz),
        .o_peak_rate (peak_rate),
        .o_start_exp (start_exp),
        .o_busy      (derive_busy)
    );

    trme_div #(
        .MANTISSA_BITS         (MANTISSA_BITS),
        .CREDITS_PER_BYTE_LOG2 (CREDITS_PER_BYTE_LOG2),
        .RATE_SEL_W            (RW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_rate      (rate_sel),
        .i_hz        (hz),
        .i_start_exp (start_exp),
        .o_stat      (div_stat),
        .o_mant      (div_mant),
        .o_exp       (div_exp)
    );

    assign i_in.ready = (r_state == S_IDLE) && !derive_busy;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign rate_ext = RW'(r_rate);
    assign max_ext  = RW'(peak_rate);
    assign over     = (rate_ext > max_ext);
    assign rate_sel = over ? max_ext : rate_ext;
    assign no_clock = (start_exp > START_LAST);

    always_comb begin
        n_state      = r_state;
        n_res_mant   = r_res_mant;
        n_res_exp    = r_res_exp;
        n_res_status = r_res_status;
        div_start    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (over && !r_clamp) begin
                    n_res_mant   = '0;
                    n_res_exp    = '0;
                    n_res_status = ST_REJECT;
                    n_state      = S_DONE;
                end else if (no_clock) begin
                    n_res_mant   = '0;
                    n_res_exp    = '0;
                    n_res_status = ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (div_stat.range_err) begin
                        n_res_mant   = '0;
                        n_res_exp    = '0;
                        n_res_status = ST_RANGE;
                    end else begin
                        n_res_mant   = div_mant;
                        n_res_exp    = div_exp;
                        n_res_status = ST_OK;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rate  <= i_in.rate_bytes;
            r_clamp <= i_in.clamp;
        end
        r_res_mant   <= n_res_mant;
        r_res_exp    <= n_res_exp;
        r_res_status <= n_res_status;
        // Hand the finished result to the output register on a free slot
        if (r_state == S_DONE && out_free) begin
            r_out_mant   <= r_res_mant;
            r_out_exp    <= r_res_exp;
            r_out_status <= r_res_status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.mantissa = r_out_mant;
    assign o_out.exponent = r_out_exp;
    assign o_out.status   = r_out_status;

`ifndef NO_ASSERTIONS
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CHECK))
        else $error("accepted transfer did not enter the rate check");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_error_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |->
            (o_out.mantissa == '0 && o_out.exponent == '0))
        else $error("error result carries a nonzero mantissa or exponent");
`endif

endmodule
